// ===== rtl/core/pru_pkg.sv =====
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and constants of the pixel replicate upscaler: request
// payloads, configuration register indexes and limits.
// ----------------------------------------------------------------------------
package pru_pkg;

  // Field widths
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int SCALE_W    = 7;
  localparam int SRC_W      = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  // Scale limit and padding byte value
  localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd100;
  localparam logic [CHAN_W-1:0]  PAD_BYTE  = 8'h00;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = 1'b1;

  // Input op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // Input request payload
  typedef struct packed {
    logic              op;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_red;
  } in_item_t;

  // Result request payload
  typedef struct packed {
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
    logic              is_pad;
    logic              row_last;
    logic              source_row_done;
  } out_item_t;

endpackage

// ===== rtl/core/pru_stream_if.sv =====
// ----------------------------------------------------------------------------
// pru_stream_if
// Valid/ready stream channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface pru_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/pru_ram.sv =====
// ----------------------------------------------------------------------------
// pru_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module pru_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/pixel_replicate_upscaler_core.sv =====
// ----------------------------------------------------------------------------
// pixel_replicate_upscaler_core
// Integer nearest-neighbor upscaler for 24-bit pixel rows. Loads fill a line
// store; emits walk the stored row, repeating each pixel scale times across,
// appending zero padding bytes to a 4-byte row boundary, and giving the whole
// row scale times.
//
//   Channel   Dir  Handshake      Contents
//   in_chan   in   valid/ready    op, in_blue, in_green, in_red
//   out_chan  out  valid/ready    out_blue/green/red, is_pad, row_last,
//                                 source_row_done
//   cfg_*     in   write enable   register index, 11-bit write data
//
// One request is taken per cycle while in_chan ready is high; the result of an emit
// request passes through the line store read, then the output register.
// Reset (synchronous, rst_n low) clears all counters and the row-held flag;
// the line store holds no data until loaded.
// A stall on out_chan holds the result and one more in the read stage; in_chan
// ready drops only when both are full and the output is not taken.
// ----------------------------------------------------------------------------
module pixel_replicate_upscaler_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pru_stream_if.sink                    in_chan,
  pru_stream_if.source                  out_chan,
  input  logic                          cfg_we,
  input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pru_pkg::*;

  localparam int CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int AW    = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;

  // Configuration registers
  logic [SCALE_W-1:0] cfg_scale_r;
  logic [SRC_W-1:0]   cfg_width_r;

  // Row walk state
  logic [CNT_W-1:0]   load_col_r,  load_col_nxt;
  logic               row_ready_r, row_ready_nxt;
  logic [AW-1:0]      emit_col_r,  emit_col_nxt;
  logic [SCALE_W-1:0] across_r,    across_nxt;
  logic [SCALE_W-1:0] down_r,      down_nxt;
  logic [1:0]         pad_cnt_r,   pad_cnt_nxt;
  logic               pad_phase_r, pad_phase_nxt;

  // Read stage and output register
  logic      s1_valid_r;
  logic      s1_pad_r;
  logic      s1_last_r;
  logic      s1_done_r;
  logic      out_valid_r;
  out_item_t out_r;

  // Handshake and decode
  in_item_t         in_item;
  logic             in_fire;
  logic             store_we;
  logic             emit_go;
  logic             out_load;
  logic             row_end;
  logic             row_done;
  logic [SCALE_W-1:0] eff_scale;
  logic [CNT_W-1:0] eff_width;
  logic [CNT_W-1:0] load_inc;
  logic [CNT_W-1:0] emit_inc;
  logic [SCALE_W-1:0] across_inc;
  logic [SCALE_W-1:0] down_inc;
  logic [2:0]       pad_inc;
  logic [1:0]       pad_len;
  logic [PIX_W-1:0] rd_pixel;

  assign in_item  = in_chan.payload;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign store_we = in_fire && (in_item.op == OP_LOAD) && !row_ready_r;
  assign emit_go  = in_fire && (in_item.op == OP_EMIT) && row_ready_r;

  // Pipeline flow: output takes the read stage when free or drained
  assign out_load      = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || out_load;

  // Clamp the configured scale and width into range
  always_comb begin
    if (cfg_scale_r == '0) begin
      eff_scale = SCALE_W'(1);
    end else if (cfg_scale_r > SCALE_MAX) begin
      eff_scale = SCALE_MAX;
    end else begin
      eff_scale = cfg_scale_r;
    end
    if (cfg_width_r == '0) begin
      eff_width = CNT_W'(1);
    end else if (int'(cfg_width_r) > MAX_WIDTH) begin
      eff_width = CNT_W'(MAX_WIDTH);
    end else begin
      eff_width = CNT_W'(cfg_width_r);
    end
  end

  // Row is 3*w*s bytes; bytes to the next multiple of 4 equal (w*s) mod 4
  assign pad_len = 2'(eff_width) * 2'(eff_scale);

  assign load_inc   = load_col_r + CNT_W'(1);
  assign emit_inc   = CNT_W'(emit_col_r) + CNT_W'(1);
  assign across_inc = across_r + SCALE_W'(1);
  assign down_inc   = down_r + SCALE_W'(1);
  assign pad_inc    = {1'b0, pad_cnt_r} + 3'd1;

  // Advance load and emit counters
  always_comb begin
    load_col_nxt  = load_col_r;
    row_ready_nxt = row_ready_r;
    emit_col_nxt  = emit_col_r;
    across_nxt    = across_r;
    down_nxt      = down_r;
    pad_cnt_nxt   = pad_cnt_r;
    pad_phase_nxt = pad_phase_r;
    row_end       = 1'b0;
    row_done      = 1'b0;

    if (store_we) begin
      load_col_nxt = load_inc;
      if (load_inc >= eff_width) begin
        load_col_nxt  = '0;
        row_ready_nxt = 1'b1;
        emit_col_nxt  = '0;
        across_nxt    = '0;
        down_nxt      = '0;
        pad_cnt_nxt   = '0;
        pad_phase_nxt = 1'b0;
      end
    end

    if (emit_go) begin
      if (!pad_phase_r) begin
        across_nxt = across_inc;
        if (across_inc >= eff_scale) begin
          across_nxt = '0;
          if (emit_inc >= eff_width) begin
            if (pad_len != 2'd0) begin
              pad_phase_nxt = 1'b1;
              pad_cnt_nxt   = '0;
            end else begin
              row_end = 1'b1;
            end
          end else begin
            emit_col_nxt = emit_col_r + AW'(1);
          end
        end
      end else begin
        pad_cnt_nxt = pad_inc[1:0];
        if (pad_inc >= {1'b0, pad_len}) begin
          row_end = 1'b1;
        end
      end

      // Close the output row; after the last copy release the store
      if (row_end) begin
        emit_col_nxt  = '0;
        across_nxt    = '0;
        pad_cnt_nxt   = '0;
        pad_phase_nxt = 1'b0;
        down_nxt      = down_inc;
        if (down_inc >= eff_scale) begin
          down_nxt      = '0;
          row_ready_nxt = 1'b0;
          row_done      = 1'b1;
        end
      end
    end
  end

  // Line store
  pru_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (load_col_r[AW-1:0]),
    .wr_data ({in_item.in_red, in_item.in_green, in_item.in_blue}),
    .rd_en   (emit_go && !pad_phase_r),
    .rd_addr (emit_col_r),
    .rd_data (rd_pixel)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_scale_r <= SCALE_W'(1);
      cfg_width_r <= SRC_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE_FACTOR: cfg_scale_r <= cfg_data[SCALE_W-1:0];
        REG_SOURCE_WIDTH: cfg_width_r <= cfg_data[SRC_W-1:0];
        default: ;
      endcase
    end
  end

  // Row walk state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_col_r  <= '0;
      row_ready_r <= 1'b0;
      emit_col_r  <= '0;
      across_r    <= '0;
      down_r      <= '0;
      pad_cnt_r   <= '0;
      pad_phase_r <= 1'b0;
    end else begin
      load_col_r  <= load_col_nxt;
      row_ready_r <= row_ready_nxt;
      emit_col_r  <= emit_col_nxt;
      across_r    <= across_nxt;
      down_r      <= down_nxt;
      pad_cnt_r   <= pad_cnt_nxt;
      pad_phase_r <= pad_phase_nxt;
    end
  end

  // Read stage: hold flags alongside the store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (emit_go) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      s1_pad_r  <= pad_phase_r;
      s1_last_r <= row_end;
      s1_done_r <= row_done;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.out_blue        <= s1_pad_r ? PAD_BYTE : rd_pixel[CHAN_W-1:0];
      out_r.out_green       <= s1_pad_r ? PAD_BYTE : rd_pixel[2*CHAN_W-1:CHAN_W];
      out_r.out_red         <= s1_pad_r ? PAD_BYTE : rd_pixel[PIX_W-1:2*CHAN_W];
      out_r.is_pad          <= s1_pad_r;
      out_r.row_last        <= s1_last_r;
      out_r.source_row_done <= s1_done_r;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

endmodule

// ===== sim/pixel_replicate_upscaler_core_tb.sv =====
// ----------------------------------------------------------------------------
// pixel_replicate_upscaler_core_tb
// Self-checking bench for the pixel replicate upscaler. A short directed table
// runs at the reset settings, followed by a sweep of register extremes and
// random settings. The sweep and random phases stream source rows of random
// pixels with stray loads and early emits mixed in; the top scale is checked
// over one output row, and the held row is then finished at scale 1. A
// request-level predictor tracks the line store and the row, column, repeat
// and padding counters. Every result is checked field by field against it or
// against the typed result of a directed row. Both channels idle at random,
// and the result side holds off for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
module pixel_replicate_upscaler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pru_pkg::*;

  localparam int MAX_W       = 1024;
  localparam int RAND_ITEMS  = 1000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int N_DIR       = 16;
  localparam int N_SWEEP     = 4;

  // Directed row: request, whether the result is typed in, typed result
  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  // Reset settings: one pixel per row, no repeat, one pad byte per row.
  // want = {blue, green, red, is_pad, row_last, source_row_done}
  localparam dir_row_t DIR_TBL [N_DIR] = '{
    {OP_EMIT, 24'h000000, 1'b0, 24'h000000, 3'b000},  // emit with no row held
    {OP_LOAD, 24'hffffff, 1'b0, 24'h000000, 3'b000},
    {OP_LOAD, 24'h123456, 1'b0, 24'h000000, 3'b000},  // load while held
    {OP_EMIT, 24'h000000, 1'b1, 24'hffffff, 3'b000},
    {OP_EMIT, 24'h000000, 1'b1, 24'h000000, 3'b111},
    {OP_EMIT, 24'h000000, 1'b0, 24'h000000, 3'b000},  // row released
    {OP_LOAD, 24'h000000, 1'b0, 24'h000000, 3'b000},
    {OP_EMIT, 24'h000000, 1'b1, 24'h000000, 3'b000},
    {OP_LOAD, 24'ha55ac3, 1'b0, 24'h000000, 3'b000},  // load while held
    {OP_EMIT, 24'h000000, 1'b1, 24'h000000, 3'b111},
    {OP_LOAD, 24'h5aa53c, 1'b0, 24'h000000, 3'b000},
    {OP_EMIT, 24'h000000, 1'b1, 24'h5aa53c, 3'b000},
    {OP_EMIT, 24'h000000, 1'b1, 24'h000000, 3'b111},
    {OP_LOAD, 24'h80017f, 1'b0, 24'h000000, 3'b000},
    {OP_EMIT, 24'h000000, 1'b0, 24'h000000, 3'b000},
    {OP_EMIT, 24'h000000, 1'b0, 24'h000000, 3'b000}
  };

  // Register extremes, out-of-range values included, and rows per setting
  localparam logic [SCALE_W-1:0] SWEEP_SCALE [N_SWEEP] =
    '{7'd0, 7'd2, 7'd0, 7'd6};
  localparam logic [SRC_W-1:0] SWEEP_WIDTH [N_SWEEP] =
    '{11'd0, 11'd3, 11'd5, 11'd0};
  localparam int SWEEP_ROWS [N_SWEEP] = '{2, 2, 1, 2};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pru_stream_if #(.payload_t(in_item_t))  in_if ();
  pru_stream_if #(.payload_t(out_item_t)) out_if ();

  pixel_replicate_upscaler_core #(
    .MAX_WIDTH(MAX_W)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the registers and the upscaler state
  logic [SCALE_W-1:0] cur_scale = 7'd1;
  logic [SRC_W-1:0]   cur_width = 11'd1;
  logic [PIX_W-1:0]   line_px [MAX_W];
  int unsigned load_col   = 0;
  int unsigned emit_col   = 0;
  int unsigned across_cnt = 0;
  int unsigned down_cnt   = 0;
  int unsigned pad_cnt    = 0;
  bit          row_held   = 1'b0;
  bit          in_pad     = 1'b0;

  out_item_t pending_px [$];
  int        rows_done  = 0;
  int        fed_cnt    = 0;
  int        px_checked = 0;
  int        fail_cnt   = 0;
  int        cycle_cnt  = 0;
  bit        tx_quiet   = 1'b0;

  function automatic int unsigned scale_used();
    if (cur_scale == 0) return 1;
    if (cur_scale > SCALE_MAX) return SCALE_MAX;
    return cur_scale;
  endfunction

  function automatic int unsigned width_used();
    if (cur_width == 0) return 1;
    if (cur_width > MAX_W) return MAX_W;
    return cur_width;
  endfunction

  // Zero bytes needed to bring an output row to a multiple of four bytes
  function automatic int unsigned pad_needed();
    int unsigned row_bytes;
    row_bytes = width_used() * scale_used() * 3;
    return (4 - (row_bytes % 4)) % 4;
  endfunction

  // Advance the upscaler by one request; got flags a result, took flags a
  // request that was not ignored
  function automatic void predict_upscale(input in_item_t req, output bit got,
                                          output bit took, output out_item_t res);
    int unsigned w;
    int unsigned s;
    bit row_end;
    bit done;
    w       = width_used();
    s       = scale_used();
    got     = 1'b0;
    took    = 1'b0;
    res     = '0;
    row_end = 1'b0;
    done    = 1'b0;

    if (req.op == OP_LOAD) begin
      // drop loads while a row is still being given out
      if (row_held) return;
      took = 1'b1;
      if (load_col < MAX_W) line_px[load_col] = {req.in_blue, req.in_green, req.in_red};
      load_col++;
      if (load_col >= w) begin
        load_col   = 0;
        row_held   = 1'b1;
        emit_col   = 0;
        across_cnt = 0;
        down_cnt   = 0;
        pad_cnt    = 0;
        in_pad     = 1'b0;
      end
      return;
    end

    if (!row_held) return;
    got  = 1'b1;
    took = 1'b1;

    if (!in_pad) begin
      // repeat the stored pixel, then step to the next column
      {res.out_blue, res.out_green, res.out_red} = line_px[emit_col];
      across_cnt++;
      if (across_cnt >= s) begin
        across_cnt = 0;
        if (emit_col + 1 >= w) begin
          if (pad_needed() > 0) begin
            in_pad  = 1'b1;
            pad_cnt = 0;
          end else begin
            row_end = 1'b1;
          end
        end else begin
          emit_col++;
        end
      end
    end else begin
      res.out_blue  = PAD_BYTE;
      res.out_green = PAD_BYTE;
      res.out_red   = PAD_BYTE;
      res.is_pad    = 1'b1;
      pad_cnt++;
      if (pad_cnt >= pad_needed()) row_end = 1'b1;
    end

    // close the output row; release the store after the last copy
    if (row_end) begin
      emit_col   = 0;
      across_cnt = 0;
      pad_cnt    = 0;
      in_pad     = 1'b0;
      down_cnt++;
      if (down_cnt >= s) begin
        down_cnt = 0;
        row_held = 1'b0;
        done     = 1'b1;
        rows_done++;
      end
    end
    res.row_last        = row_end;
    res.source_row_done = done;
  endfunction

  function automatic void check_px(input out_item_t got, input out_item_t want);
    if (got.out_blue != want.out_blue) begin
      $error("out_blue: expected %0h, actual %0h", want.out_blue, got.out_blue);
      fail_cnt++;
    end
    if (got.out_green != want.out_green) begin
      $error("out_green: expected %0h, actual %0h", want.out_green, got.out_green);
      fail_cnt++;
    end
    if (got.out_red != want.out_red) begin
      $error("out_red: expected %0h, actual %0h", want.out_red, got.out_red);
      fail_cnt++;
    end
    if (got.is_pad != want.is_pad) begin
      $error("is_pad: expected %0b, actual %0b", want.is_pad, got.is_pad);
      fail_cnt++;
    end
    if (got.row_last != want.row_last) begin
      $error("row_last: expected %0b, actual %0b", want.row_last, got.row_last);
      fail_cnt++;
    end
    if (got.source_row_done != want.source_row_done) begin
      $error("source_row_done: expected %0b, actual %0b",
             want.source_row_done, got.source_row_done);
      fail_cnt++;
    end
  endfunction

  // Random pixel request with the given op
  function automatic in_item_t rand_req(input logic op);
    in_item_t req;
    req.op       = op;
    req.in_blue  = CHAN_W'($urandom_range(0, 255));
    req.in_green = CHAN_W'($urandom_range(0, 255));
    req.in_red   = CHAN_W'($urandom_range(0, 255));
    return req;
  endfunction

  // Offer one request after a random gap; predict once it is taken
  task automatic send_req(input in_item_t req, input bit typed, input out_item_t want);
    int        gap;
    bit        got;
    bit        took;
    out_item_t res;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= req;
    do @(posedge clk); while (!in_if.ready);
    predict_upscale(req, got, took, res);
    if (typed) pending_px.push_back(want);
    else if (got) pending_px.push_back(res);
    if (took) fed_cnt++;
  endtask

  // Write both registers once the block has drained
  task automatic set_config(input logic [SCALE_W-1:0] sc, input logic [SRC_W-1:0] wd);
    in_if.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCALE_FACTOR;
    cfg_data  <= CFG_DATA_W'(sc);
    @(posedge clk);
    cur_scale = sc;
    cfg_index <= REG_SOURCE_WIDTH;
    cfg_data  <= wd;
    @(posedge clk);
    cur_width = wd;
    cfg_we    <= 1'b0;
  endtask

  // Stream random pixels until n_rows more source rows have been given out;
  // mix in early emits and loads against a held row
  task automatic run_rows(input int n_rows);
    int   target;
    logic op;
    target = rows_done + n_rows;
    while (rows_done < target) begin
      if (row_held) op = ($urandom_range(0, 19) == 0) ? OP_LOAD : OP_EMIT;
      else          op = ($urandom_range(0, 9) == 0) ? OP_EMIT : OP_LOAD;
      send_req(rand_req(op), 1'b0, '0);
    end
  endtask

  // Load a whole row, then give n_emit emits of it and stop mid-row
  task automatic run_partial(input int n_emit);
    while (!row_held) send_req(rand_req(OP_LOAD), 1'b0, '0);
    for (int i = 0; i < n_emit; i++) send_req(rand_req(OP_EMIT), 1'b0, '0);
  endtask

  // Result side: random stalls, quiet stretches and two long hold-offs
  initial begin : result_sink
    int        stall;
    bit        quiet;
    out_item_t want;
    quiet = 1'b0;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      stall = quiet ? 0 : $urandom_range(0, 3);
      if (px_checked == 300 || px_checked == 4000) stall = 150;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      px_checked++;
      if (pending_px.size() == 0) begin
        $error("result with none pending: %p", out_if.payload);
        fail_cnt++;
      end else begin
        want = pending_px.pop_front();
        check_px(out_if.payload, want);
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int                 sel;
    logic [SCALE_W-1:0] sc;
    logic [SRC_W-1:0]   wd;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_SCALE_FACTOR;
    cfg_data      <= '0;
    rst_n         <= 1'b0;
    foreach (line_px[i]) line_px[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows at the reset settings
    for (int i = 0; i < N_DIR; i++) begin
      send_req(DIR_TBL[i].req, DIR_TBL[i].typed, DIR_TBL[i].want);
    end

    // register extremes
    for (int i = 0; i < N_SWEEP; i++) begin
      set_config(SWEEP_SCALE[i], SWEEP_WIDTH[i]);
      run_rows(SWEEP_ROWS[i]);
    end

    // scale above the top: one output row of 100 copies, then finish the
    // held row at scale 1
    set_config(7'd127, 11'd1);
    run_partial(100);
    set_config(7'd1, 11'd1);
    run_rows(1);

    // random settings; keep large scales to narrow rows and vice versa
    fed_cnt = 0;
    while (fed_cnt < RAND_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        sc = '0;
        wd = SRC_W'($urandom_range(1, 12));
      end else if (sel == 1) begin
        sc = SCALE_W'($urandom_range(8, 16));
        wd = SRC_W'($urandom_range(1, 3));
      end else if (sel == 2) begin
        sc = SCALE_W'($urandom_range(1, 2));
        wd = SRC_W'($urandom_range(13, 60));
      end else if (sel == 3) begin
        sc = SCALE_W'($urandom_range(1, 6));
        wd = '0;
      end else begin
        sc = SCALE_W'($urandom_range(1, 6));
        wd = SRC_W'($urandom_range(1, 12));
      end
      set_config(sc, wd);
      run_rows($urandom_range(1, 3));
    end

    // drain, then allow the read and output stages to settle
    in_if.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
